@@ rtl/lzhc_pkg.sv @@
package lzhc_pkg;

  localparam int WIN_SIZE_DEF    = 32768;
  localparam int HASH_BITS_DEF   = 15;
  localparam int ROLL_SHIFT      = 5;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 15;
  localparam int OUT_HASH_W      = 15;
  localparam int ENTRY_POS_W     = 16;

  localparam logic OP_WARMUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

@@ rtl/lz77_hash_chain_insert.sv @@
// An accepted item passes the head read, the recorded-hash read and the output register.
// Throughput: one item per cycle unless out_ready stalls; the head table read/write
// and the recorded-hash read sit in separate pipeline stages, so items follow back to back.
// Reset: the hash register clears, then a sweep with a max(HASH_BITS, log2(WIN_SIZE))-bit
// address marks every table entry invalid; in_ready stays low meanwhile.
// WIN_SIZE must be a power of two.
module lz77_hash_chain_insert import lzhc_pkg::*; #(
  parameter int WIN_SIZE  = WIN_SIZE_DEF,
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [POS_W-1:0]      window_pos,
  input  logic                  lookahead_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_HASH_W-1:0] hash_value,
  output logic [POS_W-1:0]      chain_link,
  output logic                  link_found
);

  localparam int WIN_BITS   = $clog2(WIN_SIZE);
  localparam int HASH_DEPTH = 1 << HASH_BITS;
  localparam int CLR_BITS   = (HASH_BITS > WIN_BITS) ? HASH_BITS : WIN_BITS;

  logic                 clr_busy;
  logic [CLR_BITS-1:0]  clr_addr;
  logic [HASH_BITS-1:0] hash_next;
  logic                 acc;
  logic [ENTRY_POS_W-1:0] pos_ext;
  logic [WIN_BITS-1:0]  slot_in;

  // Pipeline control.
  logic v1, v2;
  logic adv_o, take2, mv1, mv2, take1;

  // Stage 1: head entry read in flight.
  logic                 s1_insert;
  logic [HASH_BITS-1:0] s1_hash;
  logic [WIN_BITS-1:0]  s1_slot;
  // Stage 2: recorded hash read in flight.
  logic                 s2_insert;
  logic [HASH_BITS-1:0] s2_hash;
  logic [WIN_BITS-1:0]  s2_slot;
  logic                 s2_head_valid;
  logic [WIN_BITS-1:0]  s2_head_slot;

  // Table ports.
  logic                 head_we;
  logic [HASH_BITS-1:0] head_waddr;
  logic [WIN_BITS:0]    head_wdata;
  logic [WIN_BITS:0]    head_rdata;
  logic                 rec_we;
  logic [WIN_BITS-1:0]  rec_waddr;
  logic [HASH_BITS:0]   rec_wdata;
  logic [HASH_BITS:0]   rec_rdata;

  logic                   found;
  logic [WIN_BITS-1:0]    link_slot;
  logic [ENTRY_POS_W-1:0] link_ext;
  logic [ENTRY_POS_W-1:0] hash_ext;

  lzhc_clear_seq #(.CLR_BITS(CLR_BITS)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  lzhc_hash_reg #(.HASH_BITS(HASH_BITS)) u_hash (
    .clk             (clk),
    .rst             (rst),
    .load            (acc),
    .operation       (operation),
    .data_byte       (data_byte),
    .lookahead_valid (lookahead_valid),
    .hash_next       (hash_next)
  );

  assign adv_o    = !out_valid || out_ready;
  assign take2    = !v2 || adv_o;
  assign mv2      = v2 && adv_o;
  assign mv1      = v1 && take2;
  assign take1    = !v1 || take2;
  assign in_ready = take1 && !clr_busy;
  assign acc      = in_valid && in_ready;

  assign pos_ext = ENTRY_POS_W'(window_pos);
  assign slot_in = pos_ext[WIN_BITS-1:0];

  // The head entry is read and overwritten in the same cycle; the read returns the old head.
  always_comb begin
    if (clr_busy) begin
      head_we    = 1'b1;
      head_waddr = clr_addr[HASH_BITS-1:0];
      head_wdata = '0;
      rec_we     = 1'b1;
      rec_waddr  = clr_addr[WIN_BITS-1:0];
      rec_wdata  = '0;
    end else begin
      head_we    = acc && (operation == OP_INSERT);
      head_waddr = hash_next;
      head_wdata = {1'b1, slot_in};
      rec_we     = acc && (operation == OP_INSERT);
      rec_waddr  = slot_in;
      rec_wdata  = {1'b1, hash_next};
    end
  end

  lzhc_ram #(.DEPTH(HASH_DEPTH), .WIDTH(WIN_BITS + 1)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (acc),
    .raddr (hash_next),
    .rdata (head_rdata)
  );

  // The recorded hash of this item's own slot is written at accept, before this read,
  // so a reinsert at the head's slot sees its own hash.
  lzhc_ram #(.DEPTH(WIN_SIZE), .WIDTH(HASH_BITS + 1)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (mv1),
    .raddr (head_rdata[WIN_BITS-1:0]),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= acc || (v1 && !take2);
      v2        <= mv1 || (v2 && !adv_o);
      out_valid <= mv2 || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_insert <= (operation == OP_INSERT);
      s1_hash   <= hash_next;
      s1_slot   <= slot_in;
    end
    if (mv1) begin
      s2_insert     <= s1_insert;
      s2_hash       <= s1_hash;
      s2_slot       <= s1_slot;
      s2_head_valid <= head_rdata[WIN_BITS];
      s2_head_slot  <= head_rdata[WIN_BITS-1:0];
    end
    if (mv2) begin
      hash_value <= hash_ext[OUT_HASH_W-1:0];
      chain_link <= link_ext[POS_W-1:0];
      link_found <= found;
    end
  end

  always_comb begin
    found = s2_insert && s2_head_valid && rec_rdata[HASH_BITS]
            && (rec_rdata[HASH_BITS-1:0] == s2_hash);
    if (!s2_insert) begin
      link_slot = '0;
    end else if (found) begin
      link_slot = s2_head_slot;
    end else begin
      link_slot = s2_slot;
    end
    link_ext = ENTRY_POS_W'(link_slot);
    hash_ext = ENTRY_POS_W'(s2_hash);
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("input accepted during table clear");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> (clr_addr == '0))
    else $error("table clear ended before sweeping every entry");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !take2) |=> (v1 && $stable(s1_hash) && $stable(head_rdata)))
    else $error("stalled stage 1 lost its head read");

endmodule

@@ rtl/lzhc_ram.sv @@
module lzhc_ram import lzhc_pkg::*; #(
  parameter int DEPTH = WIN_SIZE_DEF,
  parameter int WIDTH = HASH_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ rtl/lzhc_clear_seq.sv @@
module lzhc_clear_seq import lzhc_pkg::*; #(
  parameter int CLR_BITS = HASH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  output logic                busy,
  output logic [CLR_BITS-1:0] addr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      addr <= addr + 1'b1;
      if (addr == {CLR_BITS{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/lzhc_hash_reg.sv @@
module lzhc_hash_reg import lzhc_pkg::*; #(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 operation,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 lookahead_valid,
  output logic [HASH_BITS-1:0] hash_next
);

  logic [HASH_BITS-1:0] hash;
  logic [BYTE_W-1:0]    shift_byte;

  // An insert past the end of the stream hashes a zero byte.
  always_comb begin
    if (operation == OP_INSERT && !lookahead_valid) begin
      shift_byte = '0;
    end else begin
      shift_byte = data_byte;
    end
    hash_next = {hash[HASH_BITS-ROLL_SHIFT-1:0], {ROLL_SHIFT{1'b0}}}
                ^ HASH_BITS'(shift_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (load) begin
      hash <= hash_next;
    end
  end

endmodule

@@ test/tb_lz77_hash_chain_insert.sv @@
module tb_lz77_hash_chain_insert;
  import lzhc_pkg::*;

  localparam int HASH_DEPTH  = 1 << HASH_BITS_DEF;
  localparam int IDLE_LIMIT  = 150000;
  localparam int ITEM_TARGET = 1200;

  typedef struct packed {
    logic [OUT_HASH_W-1:0] hval;
    logic [POS_W-1:0]      link;
    logic                  found;
  } link_result_t;

  class chain_link_board;
    bit [OUT_HASH_W-1:0] hash_reg;
    bit [POS_W-1:0]      head_slot [HASH_DEPTH];
    bit                  head_live [HASH_DEPTH];
    bit [OUT_HASH_W-1:0] slot_hash [WIN_SIZE_DEF];
    bit                  slot_live [WIN_SIZE_DEF];
    link_result_t        pending_links [$];
    int                  errors;

    function void note_byte(logic op, logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos,
                            logic look);
      link_result_t        r;
      bit [OUT_HASH_W-1:0] wide_byte;
      bit [POS_W-1:0]      slot;
      bit [POS_W-1:0]      prev;
      r = '0;
      if (op == OP_WARMUP) begin
        wide_byte = OUT_HASH_W'(b);
        hash_reg = (hash_reg << ROLL_SHIFT) ^ wide_byte;
      end else begin
        slot = POS_W'(int'(pos) % WIN_SIZE_DEF);
        wide_byte = look ? OUT_HASH_W'(b) : '0;
        hash_reg = (hash_reg << ROLL_SHIFT) ^ wide_byte;
        // The slot's own hash is recorded before the head is tested, so a
        // head that already points here passes and links to itself.
        slot_hash[slot] = hash_reg;
        slot_live[slot] = 1'b1;
        r.link = slot;
        if (head_live[hash_reg]) begin
          prev = POS_W'(int'(head_slot[hash_reg]) % WIN_SIZE_DEF);
          if (slot_live[prev] && slot_hash[prev] == hash_reg) begin
            r.link  = prev;
            r.found = 1'b1;
          end
        end
        head_slot[hash_reg] = slot;
        head_live[hash_reg] = 1'b1;
      end
      r.hval = hash_reg;
      pending_links.push_back(r);
    endfunction

    function void check_link(logic [OUT_HASH_W-1:0] hval, logic [POS_W-1:0] link,
                             logic found);
      link_result_t r;
      if (pending_links.size() == 0) begin
        $error("result transaction with nothing pending: hash_value %h", hval);
        errors++;
        return;
      end
      r = pending_links.pop_front();
      if (hval !== r.hval) begin
        $error("hash_value expected %h actual %h", r.hval, hval);
        errors++;
      end
      if (link !== r.link) begin
        $error("chain_link expected %h actual %h", r.link, link);
        errors++;
      end
      if (found !== r.found) begin
        $error("link_found expected %b actual %b", r.found, found);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  operation = OP_WARMUP;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic [POS_W-1:0]      window_pos = '0;
  logic                  lookahead_valid = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_HASH_W-1:0] hash_value;
  logic [POS_W-1:0]      chain_link;
  logic                  link_found;

  chain_link_board board = new;
  int accepted_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int rx_tick = 0;

  lz77_hash_chain_insert dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .data_byte(data_byte),
    .window_pos(window_pos),
    .lookahead_valid(lookahead_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hash_value(hash_value),
    .chain_link(chain_link),
    .link_found(link_found)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    idle_cycles++;
    if (!rst && in_valid && in_ready) begin
      board.note_byte(operation, data_byte, window_pos, lookahead_valid);
      accepted_count++;
      idle_cycles = 0;
    end
    if (!rst && out_valid && out_ready) begin
      board.check_link(hash_value, chain_link, link_found);
      idle_cycles = 0;
    end
    // The reset sweep of the tables keeps in_ready low until every entry is cleared,
    // so the limit sits well above the length of that sweep.
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end
    stall_left--;
    rx_tick++;
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      2: out_ready = ((rx_tick % 7) < 3);
      default: out_ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(logic op, logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos,
                           logic look);
    int gap;
    int target;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    operation = op;
    data_byte = b;
    window_pos = pos;
    lookahead_valid = look;
    in_valid = 1'b1;
    target = accepted_count + 1;
    while (accepted_count < target) @(negedge clk);
    items_sent++;
  endtask

  // A deflate-style stream: two bytes prime the hash, then each position is
  // inserted with the byte two ahead; the last two positions have no lookahead.
  task automatic run_stream();
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] phrase [8];
    logic [BYTE_W-1:0] stream [$];
    int                len;
    int                mode;
    int                plen;
    int                i;
    logic              look;
    pos = ($urandom_range(0, 2) == 0) ? POS_W'($urandom_range(0, 255)) : POS_W'($urandom);
    len = $urandom_range(6, 60);
    mode = $urandom_range(0, 2);
    plen = $urandom_range(3, 8);
    foreach (phrase[k]) phrase[k] = BYTE_W'($urandom);
    for (i = 0; i < len; i++) begin
      if (mode == 0) stream.push_back(8'($urandom));
      else if (mode == 1) stream.push_back(8'($urandom_range(0, 3)));
      else stream.push_back(phrase[i % plen]);
    end
    send_item(OP_WARMUP, stream[0], POS_W'($urandom), 1'($urandom));
    send_item(OP_WARMUP, stream[1], POS_W'($urandom), 1'($urandom));
    for (i = 0; i < len; i++) begin
      look = (i + 2 < len);
      send_item(OP_INSERT, look ? stream[i + 2] : 8'($urandom), pos, look);
      pos++;
    end
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom), POS_W'($urandom),
                         1'($urandom_range(0, 1)));
  endtask

  task automatic run_broken();
    int n;
    n = $urandom_range(2, 12);
    repeat (n) send_item(OP_INSERT, BYTE_W'($urandom_range(0, 3)),
                         POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Warmup ignores position and lookahead.
    send_item(OP_WARMUP, 8'hFF, 15'h7FFF, 1'b1);
    send_item(OP_WARMUP, 8'h00, 15'h0000, 1'b0);
    send_item(OP_WARMUP, 8'hAA, 15'h3039, 1'b1);
    send_item(OP_INSERT, 8'hFF, 15'h0000, 1'b1);
    // Zero lookahead drives the hash to zero; the repeat at slot 5 links to itself.
    send_item(OP_INSERT, 8'hFF, 15'd5, 1'b0);
    send_item(OP_INSERT, 8'h00, 15'd5, 1'b0);
    send_item(OP_INSERT, 8'h00, 15'd5, 1'b0);
    send_item(OP_INSERT, 8'h00, 15'd5, 1'b0);
    send_item(OP_INSERT, 8'h00, 15'h7FFF, 1'b0);
    // Overwrite the head's slot with another hash, so the next zero hash fails
    // the recorded-hash test even though the head is valid.
    send_item(OP_INSERT, 8'h1F, 15'h7FFF, 1'b1);
    send_item(OP_WARMUP, 8'h00, 15'h0000, 1'b0);
    send_item(OP_WARMUP, 8'h00, 15'h0000, 1'b0);
    send_item(OP_WARMUP, 8'h00, 15'h0000, 1'b0);
    send_item(OP_INSERT, 8'h00, 15'd100, 1'b0);
    send_item(OP_WARMUP, 8'hFF, 15'h0000, 1'b0);
    send_item(OP_WARMUP, 8'hFF, 15'h0000, 1'b0);
    send_item(OP_INSERT, 8'hFF, 15'd300, 1'b1);
    send_item(OP_INSERT, 8'hFF, 15'd301, 1'b1);
    send_item(OP_INSERT, 8'h00, 15'h7FFF, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) run_stream();
      else if (pick < 9) run_noise();
      else run_broken();
    end
    in_valid = 1'b0;

    while (board.pending_links.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
